@@ rtl/fair_time_slice_scheduler_defines.svh @@
// assertion helpers for the scheduler; the asserting module provides clk and rst_n
`ifndef FAIR_TIME_SLICE_SCHEDULER_DEFINES_SVH
`define FAIR_TIME_SLICE_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define FTSS_CHECK(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ftss check failed");
`define FTSS_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftss implication failed");
`else
`define FTSS_CHECK(name, cond)
`define FTSS_IMPLY(name, ante, cons)
`endif

`endif

@@ rtl/ftss_pkg.sv @@
package ftss_pkg;

    localparam int ID_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // event codes
    localparam logic [2:0] FN_ATTACH  = 3'd0;
    localparam logic [2:0] FN_DETACH  = 3'd1;
    localparam logic [2:0] FN_ENABLE  = 3'd2;
    localparam logic [2:0] FN_DISABLE = 3'd3;
    localparam logic [2:0] FN_COMMIT  = 3'd4;
    localparam logic [2:0] FN_SRESET  = 3'd5;
    localparam logic [2:0] FN_TICK    = 3'd6;
    // unassigned code, ignored by the block
    localparam logic [2:0] FN_UNUSED  = 3'd7;

    // slot status
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    // result status
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_FULL     = 2'd1;
    localparam logic [1:0] RS_ATTACHED = 2'd2;
    localparam logic [1:0] RS_NOT_ATT  = 2'd3;

    // tick actions on the previous tenant
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_KEEPS    = 3'd1;
    localparam logic [2:0] ACT_FINISHED = 3'd2;
    localparam logic [2:0] ACT_ABORTED  = 3'd3;
    localparam logic [2:0] ACT_PAUSED   = 3'd4;
    localparam logic [2:0] ACT_DROPPED  = 3'd5;

    // policies
    localparam logic [1:0] POL_RR      = 2'd0;
    localparam logic [1:0] POL_ABORT   = 2'd1;
    localparam logic [1:0] POL_PREEMPT = 2'd2;
    // reserved code, behaves as round robin
    localparam logic [1:0] POL_RSVD    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    // what follows a list removal
    typedef enum logic [1:0] {
        RM_DONE,
        RM_TAIL,
        RM_SORT
    } rm_mode_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHL,
        CELL_SHR
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t       cmd;
        logic [ID_W-1:0] val;
    } cell_op_t;

endpackage

@@ rtl/ftss_if.sv @@
interface ftss_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [2:0]  tenant;
    logic [31:0] now_ms;
    logic        hw_busy;

    modport source (output valid, func, tenant, now_ms, hw_busy, input ready);
    modport sink (input valid, func, tenant, now_ms, hw_busy, output ready);
endinterface

interface ftss_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] prev_action;
    logic [2:0] prev_tenant;
    logic       launch;
    logic [2:0] launch_tenant;
    logic       hw_reset_req;
    logic       hw_pause_req;

    modport source (output valid, status, prev_action, prev_tenant, launch, launch_tenant,
                    hw_reset_req, hw_pause_req, input ready);
    modport sink (input valid, status, prev_action, prev_tenant, launch, launch_tenant,
                  hw_reset_req, hw_pause_req, output ready);
endinterface

@@ rtl/ftss_cell.sv @@
module ftss_cell #(
    parameter int TENANTS = 8,
    parameter int IDX     = 0
) (
    input  logic                            clk,
    input  ftss_pkg::cell_op_t              op,
    input  logic [$clog2(TENANTS)-1:0]      pos,
    input  logic [ftss_pkg::ID_W-1:0]       left_val,
    input  logic [ftss_pkg::ID_W-1:0]       right_val,
    output logic [ftss_pkg::ID_W-1:0]       val
);

    localparam int PW = $clog2(TENANTS);
    localparam logic [PW-1:0] MY_POS = PW'(IDX);

    logic [ftss_pkg::ID_W-1:0] val_reg;
    logic [ftss_pkg::ID_W-1:0] val_next;

    // remove shifts the tail left, insert shifts it right
    always_comb
    begin
        val_next = val_reg;
        case (op.cmd)
            ftss_pkg::CELL_SHL:
            begin
                if (MY_POS >= pos)
                begin
                    val_next = right_val;
                end
            end
            ftss_pkg::CELL_SHR:
            begin
                if (MY_POS > pos)
                begin
                    val_next = left_val;
                end
                else if (MY_POS == pos)
                begin
                    val_next = op.val;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

@@ rtl/fair_time_slice_scheduler.sv @@
// fair time-slice scheduler: shares one accelerator among up to eight tenants
// req channel: one event per transfer (attach, detach, enable, disable, commit,
//   soft reset, tick) with the tenant slot, the millisecond time and hw_busy
// rsp channel: exactly one result per event: status, what happened to the
//   previous tenant, launch of a new one, reset and pause requests
// cfg port: policy, max_period_ms and tenant_limit, to be written while idle;
//   the user must keep to this, as the block itself does not enforce it
// enable, disable, commit, soft reset and attach go straight to the result;
//   detach first walks the list to remove the tenant; a tick may walk the
//   list for the preemption check, removal, sorted reinsert and launch
//   search before its result
// throughput: one event at a time; the list walks through the order cells,
//   one position per cycle, set the rate
// a finished result waits in the output register, so the next event is
//   taken while the receiver stalls; only a second finished result waits
// reset: no tenant attached, nothing running, registers at policy round
//   robin, max period 100 ms, tenant limit 8

`include "fair_time_slice_scheduler_defines.svh"

module fair_time_slice_scheduler #(
    parameter int TENANTS   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ftss_req_if.sink                          req,
    ftss_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [ftss_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [ftss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PW = $clog2(TENANTS);
    localparam int CW = $clog2(TENANTS + 1);
    localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam int IW = ftss_pkg::ID_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_TICK   = 9'b000000010,
        S_KEEP   = 9'b000000100,
        S_FIN    = 9'b000001000,
        S_FIND   = 9'b000010000,
        S_SORT   = 9'b000100000,
        S_INS    = 9'b001000000,
        S_LAUNCH = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    function automatic logic [PW-1:0] slot(input logic [IW-1:0] t);
        return PW'(t);
    endfunction

    // control state
    state_t                state_reg, state_next;
    logic [1:0]            policy_reg;
    logic [15:0]           maxp_reg;
    logic [3:0]            limit_reg;
    logic                  valid_reg   [TENANTS];
    logic                  valid_next  [TENANTS];
    logic                  en_reg      [TENANTS];
    logic                  en_next     [TENANTS];
    logic [1:0]            status_reg  [TENANTS];
    logic [1:0]            status_next [TENANTS];
    logic [CW-1:0]         count_reg, count_next;
    logic                  cur_valid_reg, cur_valid_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [31:0]           slice_reg, slice_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [TIME_BITS-1:0]  used_reg [TENANTS];
    logic                  used_we;
    logic [PW-1:0]         used_waddr;
    logic [TIME_BITS-1:0]  used_wdata;
    logic [PW-1:0]         used_raddr;
    logic [TIME_BITS-1:0]  used_rd;
    logic [31:0]           now_reg, now_next;
    logic                  busy_reg, busy_next;
    logic [TIME_BITS-1:0]  sum_reg, sum_next;
    logic [IW-1:0]         target_reg, target_next;
    ftss_pkg::rm_mode_t    rm_reg, rm_next;
    logic [PW-1:0]         ins_reg, ins_next;
    logic [1:0]            res_st_reg, res_st_next;
    logic [2:0]            res_act_reg, res_act_next;
    logic [2:0]            res_ptn_reg, res_ptn_next;
    logic                  res_lau_reg, res_lau_next;
    logic [2:0]            res_ltn_reg, res_ltn_next;
    logic                  res_rst_reg, res_rst_next;
    logic                  res_pau_reg, res_pau_next;
    logic [1:0]            o_st_reg;
    logic [2:0]            o_act_reg, o_ptn_reg, o_ltn_reg;
    logic                  o_lau_reg, o_rst_reg, o_pau_reg;

    // order list cells
    ftss_pkg::cell_op_t    cell_op;
    logic [PW-1:0]         cell_pos;
    logic [IW-1:0]         list_val [TENANTS];
    logic [IW-1:0]         scan_val;

    // helpers
    logic                  in_xfer;
    logic                  t_ok;
    logic [PW-1:0]         ts;
    logic [PW-1:0]         cs;
    logic [PW-1:0]         ns;
    logic [31:0]           dur;
    logic [SW-1:0]         sum_full;
    logic [TIME_BITS-1:0]  sum_sat;
    logic                  fair;
    logic                  load_out;

    genvar g;
    generate
        for (g = 0; g < TENANTS; g++)
        begin : g_cell
            logic [IW-1:0] lv;
            logic [IW-1:0] rv;
            if (g == 0)
            begin : g_first
                assign lv = '0;
            end
            else
            begin : g_mid_l
                assign lv = list_val[g-1];
            end
            if (g == TENANTS - 1)
            begin : g_last
                assign rv = '0;
            end
            else
            begin : g_mid_r
                assign rv = list_val[g+1];
            end
            ftss_cell #(
                .TENANTS (TENANTS),
                .IDX     (g)
            ) u_cell (
                .clk       (clk),
                .op        (cell_op),
                .pos       (cell_pos),
                .left_val  (lv),
                .right_val (rv),
                .val       (list_val[g])
            );
        end
    endgenerate

    assign scan_val = list_val[idx_reg[PW-1:0]];
    assign ts       = slot(req.tenant);
    assign cs       = slot(cur_reg);
    assign ns       = slot(scan_val);
    assign t_ok     = (32'(req.tenant) < 32'(TENANTS));
    assign in_xfer  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign fair     = (policy_reg == ftss_pkg::POL_ABORT) ||
                      (policy_reg == ftss_pkg::POL_PREEMPT);

    // one read port on the used-time store: the current tenant while
    // settling the tick, otherwise the tenant under the list walk
    assign used_raddr = (state_reg == S_TICK) ? cs : ns;
    assign used_rd    = used_reg[used_raddr];

    // slice length and saturating running time
    assign dur      = now_reg - slice_reg;
    assign sum_full = SW'(used_rd) + SW'(dur);
    assign sum_sat  = (sum_full > SW'(TIME_MAX)) ? TIME_MAX : sum_full[TIME_BITS-1:0];

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        en_next        = en_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        slice_next     = slice_reg;
        idx_next       = idx_reg;
        now_next       = now_reg;
        busy_next      = busy_reg;
        sum_next       = sum_reg;
        target_next    = target_reg;
        rm_next        = rm_reg;
        ins_next       = ins_reg;
        res_st_next    = res_st_reg;
        res_act_next   = res_act_reg;
        res_ptn_next   = res_ptn_reg;
        res_lau_next   = res_lau_reg;
        res_ltn_next   = res_ltn_reg;
        res_rst_next   = res_rst_reg;
        res_pau_next   = res_pau_reg;
        used_we        = 1'b0;
        used_waddr     = cs;
        used_wdata     = sum_reg;
        cell_op.cmd    = ftss_pkg::CELL_HOLD;
        cell_op.val    = target_reg;
        cell_pos       = idx_reg[PW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    now_next     = req.now_ms;
                    busy_next    = req.hw_busy;
                    res_st_next  = ftss_pkg::RS_OK;
                    res_act_next = ftss_pkg::ACT_NONE;
                    res_ptn_next = '0;
                    res_lau_next = 1'b0;
                    res_ltn_next = '0;
                    res_rst_next = 1'b0;
                    res_pau_next = 1'b0;
                    idx_next     = '0;
                    state_next   = S_DONE;
                    if (req.func == ftss_pkg::FN_ATTACH)
                    begin
                        if (!t_ok)
                        begin
                            res_st_next = ftss_pkg::RS_FULL;
                        end
                        else if (valid_reg[ts])
                        begin
                            res_st_next = ftss_pkg::RS_ATTACHED;
                        end
                        else if ((32'(count_reg) >= 32'(limit_reg)) ||
                                 (32'(count_reg) >= 32'(TENANTS)))
                        begin
                            res_st_next = ftss_pkg::RS_FULL;
                        end
                        else
                        begin
                            // new tenant goes to the list head
                            valid_next[ts]  = 1'b1;
                            en_next[ts]     = 1'b0;
                            status_next[ts] = ftss_pkg::ST_IDLE;
                            used_we         = 1'b1;
                            used_waddr      = ts;
                            used_wdata      = '0;
                            cell_op.cmd     = ftss_pkg::CELL_SHR;
                            cell_op.val     = req.tenant;
                            cell_pos        = '0;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                    else if (req.func == ftss_pkg::FN_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else if ((req.func == ftss_pkg::FN_DETACH) ||
                             (req.func == ftss_pkg::FN_ENABLE) ||
                             (req.func == ftss_pkg::FN_DISABLE) ||
                             (req.func == ftss_pkg::FN_COMMIT) ||
                             (req.func == ftss_pkg::FN_SRESET))
                    begin
                        if (!t_ok || !valid_reg[ts])
                        begin
                            res_st_next = ftss_pkg::RS_NOT_ATT;
                        end
                        else if (req.func == ftss_pkg::FN_DETACH)
                        begin
                            valid_next[ts]  = 1'b0;
                            en_next[ts]     = 1'b0;
                            status_next[ts] = ftss_pkg::ST_IDLE;
                            if (cur_valid_reg && (cur_reg == req.tenant))
                            begin
                                cur_valid_next = 1'b0;
                            end
                            target_next = req.tenant;
                            rm_next     = ftss_pkg::RM_DONE;
                            state_next  = S_FIND;
                        end
                        else if (req.func == ftss_pkg::FN_ENABLE)
                        begin
                            en_next[ts] = 1'b1;
                        end
                        else if (req.func == ftss_pkg::FN_DISABLE)
                        begin
                            en_next[ts] = 1'b0;
                        end
                        else if (req.func == ftss_pkg::FN_COMMIT)
                        begin
                            status_next[ts] = ftss_pkg::ST_WAIT;
                        end
                        else
                        begin
                            if (status_reg[ts] == ftss_pkg::ST_WAIT)
                            begin
                                status_next[ts] = ftss_pkg::ST_IDLE;
                            end
                            else if (status_reg[ts] == ftss_pkg::ST_RUN)
                            begin
                                status_next[ts] = ftss_pkg::ST_IDLE;
                                res_rst_next    = 1'b1;
                                cur_valid_next  = 1'b0;
                            end
                        end
                    end
                end
            end

            S_TICK:
            begin
                idx_next = '0;
                if (!cur_valid_reg)
                begin
                    state_next = S_LAUNCH;
                end
                else
                begin
                    res_ptn_next = cur_reg;
                    sum_next     = sum_sat;
                    if (!valid_reg[cs] || !en_reg[cs] || (status_reg[cs] != ftss_pkg::ST_RUN))
                    begin
                        // stale selection: drop it and launch
                        status_next[cs] = ftss_pkg::ST_IDLE;
                        cur_valid_next  = 1'b0;
                        slice_next      = '0;
                        res_act_next    = ftss_pkg::ACT_DROPPED;
                        state_next      = S_LAUNCH;
                    end
                    else if (busy_reg && (!fair || (dur <= 32'(maxp_reg))))
                    begin
                        res_act_next = ftss_pkg::ACT_KEEPS;
                        state_next   = S_DONE;
                    end
                    else if (busy_reg && (policy_reg == ftss_pkg::POL_PREEMPT))
                    begin
                        state_next = S_KEEP;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_KEEP:
            begin
                // first other waiting tenant decides on preemption
                if (idx_reg >= count_reg)
                begin
                    res_act_next = ftss_pkg::ACT_KEEPS;
                    state_next   = S_DONE;
                end
                else if ((scan_val != cur_reg) && (status_reg[ns] == ftss_pkg::ST_WAIT))
                begin
                    if (used_rd < sum_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        res_act_next = ftss_pkg::ACT_KEEPS;
                        state_next   = S_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_FIN:
            begin
                used_we        = 1'b1;
                used_waddr     = cs;
                used_wdata     = sum_reg;
                cur_valid_next = 1'b0;
                slice_next     = '0;
                target_next    = cur_reg;
                rm_next        = fair ? ftss_pkg::RM_SORT : ftss_pkg::RM_TAIL;
                idx_next       = '0;
                state_next     = S_FIND;
                if (!busy_reg)
                begin
                    status_next[cs] = ftss_pkg::ST_IDLE;
                    res_act_next    = ftss_pkg::ACT_FINISHED;
                end
                else if (policy_reg == ftss_pkg::POL_ABORT)
                begin
                    status_next[cs] = ftss_pkg::ST_IDLE;
                    res_rst_next    = 1'b1;
                    res_act_next    = ftss_pkg::ACT_ABORTED;
                end
                else
                begin
                    status_next[cs] = ftss_pkg::ST_WAIT;
                    res_pau_next    = 1'b1;
                    res_act_next    = ftss_pkg::ACT_PAUSED;
                end
            end

            S_FIND:
            begin
                if ((idx_reg < count_reg) && (scan_val != target_reg))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (idx_reg < count_reg)
                    begin
                        cell_op.cmd = ftss_pkg::CELL_SHL;
                        cell_pos    = idx_reg[PW-1:0];
                        count_next  = count_reg - 1'b1;
                    end
                    idx_next = '0;
                    case (rm_reg)
                        ftss_pkg::RM_TAIL:
                        begin
                            ins_next   = PW'(count_next);
                            state_next = S_INS;
                        end
                        ftss_pkg::RM_SORT:
                        begin
                            state_next = S_SORT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SORT:
            begin
                // insert before the first tenant with more running time
                if ((idx_reg >= count_reg) || (used_rd > sum_reg))
                begin
                    ins_next   = idx_reg[PW-1:0];
                    state_next = S_INS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_INS:
            begin
                cell_op.cmd = ftss_pkg::CELL_SHR;
                cell_op.val = target_reg;
                cell_pos    = ins_reg;
                count_next  = count_reg + 1'b1;
                idx_next    = '0;
                state_next  = S_LAUNCH;
            end

            S_LAUNCH:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else if (status_reg[ns] == ftss_pkg::ST_WAIT)
                begin
                    status_next[ns] = ftss_pkg::ST_RUN;
                    slice_next      = now_reg;
                    cur_valid_next  = 1'b1;
                    cur_next        = scan_val;
                    res_lau_next    = 1'b1;
                    res_ltn_next    = scan_val;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            slice_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            rm_reg        <= ftss_pkg::RM_DONE;
            for (int i = 0; i < TENANTS; i++)
            begin
                valid_reg[i]  <= 1'b0;
                en_reg[i]     <= 1'b0;
                status_reg[i] <= ftss_pkg::ST_IDLE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            cur_reg       <= cur_next;
            slice_reg     <= slice_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            rm_reg        <= rm_next;
            valid_reg     <= valid_next;
            en_reg        <= en_next;
            status_reg    <= status_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= ftss_pkg::POL_RR;
            maxp_reg   <= 16'd100;
            limit_reg  <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                ftss_pkg::CFG_POLICY: policy_reg <= cfg_data[1:0];
                ftss_pkg::CFG_MAXP:   maxp_reg   <= cfg_data;
                ftss_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[3:0];
                default:              policy_reg <= policy_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        busy_reg    <= busy_next;
        sum_reg     <= sum_next;
        target_reg  <= target_next;
        ins_reg     <= ins_next;
        res_st_reg  <= res_st_next;
        res_act_reg <= res_act_next;
        res_ptn_reg <= res_ptn_next;
        res_lau_reg <= res_lau_next;
        res_ltn_reg <= res_ltn_next;
        res_rst_reg <= res_rst_next;
        res_pau_reg <= res_pau_next;
        if (used_we)
        begin
            used_reg[used_waddr] <= used_wdata;
        end
        if (load_out)
        begin
            o_st_reg  <= res_st_reg;
            o_act_reg <= res_act_reg;
            o_ptn_reg <= res_ptn_reg;
            o_lau_reg <= res_lau_reg;
            o_ltn_reg <= res_ltn_reg;
            o_rst_reg <= res_rst_reg;
            o_pau_reg <= res_pau_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = o_st_reg;
    assign rsp.prev_action   = o_act_reg;
    assign rsp.prev_tenant   = o_ptn_reg;
    assign rsp.launch        = o_lau_reg;
    assign rsp.launch_tenant = o_ltn_reg;
    assign rsp.hw_reset_req  = o_rst_reg;
    assign rsp.hw_pause_req  = o_pau_reg;

    // list never holds more tenants than there are slots
    `FTSS_CHECK(a_count_bound, 32'(count_reg) <= 32'(TENANTS))
    // a launch leaves a valid current selection behind
    `FTSS_IMPLY(a_launch_sel, (state_reg == S_LAUNCH) && res_lau_next, cur_valid_reg)
    // an accepted event always starts work
    `FTSS_IMPLY(a_accept_busy, in_xfer, state_reg != S_IDLE)

endmodule
